>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define AST_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/gep_pkg.sv
// Types, constants and constant functions of the grain envelope shaper.
`timescale 1ns / 1ps
package gep_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAIN_LENGTH  = 3'd0,
		REG_ATTACK_LENGTH = 3'd1,
		REG_DECAY_LENGTH  = 3'd2,
		REG_WARP_EXPONENT = 3'd3,
		REG_LEFT_GAIN     = 3'd4,
		REG_RIGHT_GAIN    = 3'd5,
		REG_STEREO_SOURCE = 3'd6
	} cfg_reg_t;

	localparam logic [15:0] RST_GRAIN  = 16'd1024;
	localparam logic [15:0] RST_ATTACK = 16'd64;
	localparam logic [15:0] RST_DECAY  = 16'd64;
	localparam logic [15:0] RST_WARP   = 16'd4096;
	localparam logic [15:0] RST_GAIN   = 16'd8192;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic signed [15:0] sample_left;
		logic signed [15:0] sample_right;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic               grain_end;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SETUP,
		OP_DIV,
		OP_XSEL,
		OP_LOGI,
		OP_LOG,
		OP_QMUL,
		OP_EXP,
		OP_YSEL,
		OP_ENV,
		OP_SHAPE,
		OP_GAINL,
		OP_GAINR,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		logic        sel;   // 0: attack factor, 1: decay factor
		logic [4:0]  step;
	} dp_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_XSEL,
		ST_LOGI,
		ST_LOG,
		ST_QMUL,
		ST_EXP,
		ST_YSEL,
		ST_ENV,
		ST_SHAPE,
		ST_GAINL,
		ST_GAINR,
		ST_DONE
	} ctrl_state_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q0.30 constant 2^(-2^-(k+1)).
	function automatic logic [29:0] root_const(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int i = 0; i < k; i++) begin
			c = isqrt64(c << 30);
		end
		return c[29:0];
	endfunction

endpackage

>>> rtl/gep_ctrl.sv
// Sequencer that steps the shaper datapath through one frame.
`timescale 1ns / 1ps
module gep_ctrl #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output gep_pkg::dp_cmd_t cmd
);
	import gep_pkg::*;

	localparam logic [4:0] DivLast = 5'd15;
	localparam logic [4:0] IterLast = 5'(LOG_TABLE_BITS - 1);

	ctrl_state_t state_q, state_d;
	logic [4:0]  cnt_q;
	logic        sel_q;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_DIV;
			ST_DIV:   if (cnt_q == DivLast) state_d = ST_XSEL;
			ST_XSEL:  state_d = ST_LOGI;
			ST_LOGI:  state_d = ST_LOG;
			ST_LOG:   if (cnt_q == IterLast) state_d = ST_QMUL;
			ST_QMUL:  state_d = ST_EXP;
			ST_EXP:   if (cnt_q == IterLast) state_d = ST_YSEL;
			ST_YSEL:  state_d = sel_q ? ST_ENV : ST_SETUP;
			ST_ENV:   state_d = ST_SHAPE;
			ST_SHAPE: state_d = ST_GAINL;
			ST_GAINL: state_d = ST_GAINR;
			ST_GAINR: state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.sel  = sel_q;
		cmd.step = cnt_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_SETUP: cmd.op = OP_SETUP;
			ST_DIV:   cmd.op = OP_DIV;
			ST_XSEL:  cmd.op = OP_XSEL;
			ST_LOGI:  cmd.op = OP_LOGI;
			ST_LOG:   cmd.op = OP_LOG;
			ST_QMUL:  cmd.op = OP_QMUL;
			ST_EXP:   cmd.op = OP_EXP;
			ST_YSEL:  cmd.op = OP_YSEL;
			ST_ENV:   cmd.op = OP_ENV;
			ST_SHAPE: cmd.op = OP_SHAPE;
			ST_GAINL: cmd.op = OP_GAINL;
			ST_GAINR: cmd.op = OP_GAINR;
			ST_DONE:  if (out_free) cmd.op = OP_OUT;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DIV || state_q == ST_LOG || state_q == ST_EXP)
			    && state_d == state_q) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_IDLE) sel_q <= 1'b0;
			else if (state_q == ST_YSEL) sel_q <= 1'b1;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/gep_datapath.sv
// Shaper datapath: config registers, frame counter, divider, log/exp and shared multiplier.
`timescale 1ns / 1ps
module gep_datapath #(
	parameter int FRAME_COUNT_BITS = 16,
	parameter int LOG_TABLE_BITS   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gep_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gep_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  gep_pkg::in_item_t                 in_data,
	input  gep_pkg::dp_cmd_t                  cmd,
	output gep_pkg::out_item_t                out_data
);
	import gep_pkg::*;

	localparam int PW  = FRAME_COUNT_BITS;
	localparam int CW  = ((PW > 16) ? PW : 16) + 1;
	localparam int F   = LOG_TABLE_BITS;
	localparam int LW  = F + 5;
	localparam int RIW = $clog2(F);

	typedef enum logic [1:0] {K_QUO, K_ONE, K_ZERO} lin_kind_t;

	logic [15:0] grain_q, attack_q, decay_q, warp_q, lgain_q, rgain_q;
	logic        stereo_q;
	logic [PW-1:0] pos_q;

	logic [15:0] a_q, d_q, s0_q;
	logic [PW-1:0] p_q;
	logic        last_q;
	logic signed [15:0] src_q;
	lin_kind_t   kind_q;
	logic [15:0] rem_q, quo_q, den_q;
	logic [16:0] x_q;
	logic [3:0]  e_q;
	logic [15:0] m_q;
	logic [F-1:0] f_q;
	logic [8:0]  n_q;
	logic [F-1:0] rsh_q;
	logic [30:0] z_q;
	logic [16:0] fa_q, fd_q, env_q;
	logic signed [16:0] shaped_q;
	logic signed [15:0] left_q, right_q;
	out_item_t   out_q;

	logic [29:0] root_tab [F];
	for (genvar i = 0; i < F; i++) begin : g_root
		localparam logic [29:0] RootC = root_const(i);
		assign root_tab[i] = RootC;
	end

	// Frame setup values
	logic [15:0] g_eff, a_eff, d_one, d_eff;
	logic [PW:0] p_inc;
	logic        last_c;
	logic signed [16:0] lr_sum;
	always_comb begin
		g_eff  = (grain_q == '0) ? 16'd1 : grain_q;
		a_eff  = (attack_q == '0) ? 16'd1 : attack_q;
		d_one  = (decay_q == '0) ? 16'd1 : decay_q;
		d_eff  = (d_one > g_eff) ? g_eff : d_one;
		p_inc  = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};
		last_c = (CW'(p_inc) >= CW'(g_eff)) || (pos_q == '1);
		lr_sum = 17'(in_data.sample_left) + 17'(in_data.sample_right);
	end

	// Linear factor selection
	logic [CW-1:0] p_ext, j_c;
	always_comb begin
		p_ext = CW'(p_q);
		j_c   = p_ext - CW'(s0_q);
	end

	// Divider step
	logic [16:0] dtwo, ddiff;
	always_comb begin
		dtwo  = {rem_q, 1'b0};
		ddiff = dtwo - {1'b0, den_q};
	end

	// Leading one of the factor
	logic [3:0] e_c;
	always_comb begin
		e_c = '0;
		for (int k = 0; k < 16; k++) begin
			if (x_q[k]) e_c = 4'(k);
		end
	end

	logic [LW-1:0] lneg;
	assign lneg = {5'd16 - {1'b0, e_q}, {F{1'b0}}} - LW'(f_q);

	// Shared multiplier
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_LOG: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			OP_QMUL: begin
				mul_a = 32'(lneg);
				mul_b = 32'(warp_q);
			end
			OP_EXP: begin
				mul_a = 32'(z_q);
				mul_b = 32'(root_tab[cmd.step[RIW-1:0]]);
			end
			OP_ENV: begin
				mul_a = 32'(fa_q);
				mul_b = 32'(fd_q);
			end
			OP_SHAPE: begin
				mul_a = {{16{src_q[15]}}, src_q};
				mul_b = 32'(env_q);
			end
			OP_GAINL: begin
				mul_a = {{15{shaped_q[16]}}, shaped_q};
				mul_b = 32'(lgain_q);
			end
			OP_GAINR: begin
				mul_a = {{15{shaped_q[16]}}, shaped_q};
				mul_b = 32'(rgain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	logic [16:0] sq;
	assign sq = prod[31:15];

	logic signed [20:0] gain_v;
	logic signed [15:0] gain_sat;
	always_comb begin
		gain_v = prod[33:13];
		if (gain_v > 21'sd32767) gain_sat = 16'sh7FFF;
		else if (gain_v < -21'sd32768) gain_sat = -16'sh8000;
		else gain_sat = gain_v[15:0];
	end

	logic [16:0] y_c;
	logic [30:0] z_sh;
	always_comb begin
		z_sh = z_q >> (5'd14 + n_q[4:0]);
		if (warp_q == '0 || x_q[16]) y_c = ONE_Q16;
		else if (x_q == '0) y_c = '0;
		else if (n_q > 9'd16) y_c = '0;
		else y_c = z_sh[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grain_q  <= RST_GRAIN;
			attack_q <= RST_ATTACK;
			decay_q  <= RST_DECAY;
			warp_q   <= RST_WARP;
			lgain_q  <= RST_GAIN;
			rgain_q  <= RST_GAIN;
			stereo_q <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GRAIN_LENGTH:  grain_q  <= cfg_data;
					REG_ATTACK_LENGTH: attack_q <= cfg_data;
					REG_DECAY_LENGTH:  decay_q  <= cfg_data;
					REG_WARP_EXPONENT: warp_q   <= cfg_data;
					REG_LEFT_GAIN:     lgain_q  <= cfg_data;
					REG_RIGHT_GAIN:    rgain_q  <= cfg_data;
					REG_STEREO_SOURCE: stereo_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.op == OP_LOAD) pos_q <= last_c ? '0 : p_inc[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				a_q    <= a_eff;
				d_q    <= d_eff;
				s0_q   <= g_eff - d_eff;
				p_q    <= pos_q;
				last_q <= last_c;
				src_q  <= stereo_q ? lr_sum[16:1] : in_data.sample_left;
			end
			OP_SETUP: begin
				quo_q <= '0;
				if (!cmd.sel) begin
					den_q  <= a_q;
					rem_q  <= 16'(p_q);
					kind_q <= (p_ext < CW'(a_q)) ? K_QUO : K_ONE;
				end else begin
					den_q <= d_q;
					rem_q <= d_q - j_c[15:0];
					if (p_ext < CW'(s0_q)) kind_q <= K_ONE;
					else if (j_c >= CW'(d_q)) kind_q <= K_ZERO;
					else if (j_c == '0) kind_q <= K_ONE;
					else kind_q <= K_QUO;
				end
			end
			OP_DIV: begin
				if (!ddiff[16]) begin
					rem_q <= ddiff[15:0];
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= dtwo[15:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
			end
			OP_XSEL: begin
				case (kind_q)
					K_ONE:   x_q <= ONE_Q16;
					K_ZERO:  x_q <= '0;
					default: x_q <= {1'b0, quo_q};
				endcase
			end
			OP_LOGI: begin
				e_q <= e_c;
				m_q <= x_q[15:0] << (4'd15 - e_c);
				f_q <= '0;
			end
			OP_LOG: begin
				if (sq[16]) begin
					m_q <= sq[16:1];
					f_q <= {f_q[F-2:0], 1'b1};
				end else begin
					m_q <= sq[15:0];
					f_q <= {f_q[F-2:0], 1'b0};
				end
			end
			OP_QMUL: begin
				n_q   <= prod[F+20:F+12];
				rsh_q <= prod[F+11:12];
				z_q   <= 31'h4000_0000;
			end
			OP_EXP: begin
				if (rsh_q[F-1]) z_q <= prod[60:30];
				rsh_q <= {rsh_q[F-2:0], 1'b0};
			end
			OP_YSEL: begin
				if (cmd.sel) fd_q <= y_c;
				else fa_q <= y_c;
			end
			OP_ENV:   env_q    <= prod[32:16];
			OP_SHAPE: shaped_q <= prod[32:16];
			OP_GAINL: left_q   <= gain_sat;
			OP_GAINR: right_q  <= gain_sat;
			OP_OUT: begin
				out_q.out_left  <= left_q;
				out_q.out_right <= right_q;
				out_q.grain_end <= last_q;
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

>>> rtl/grain_envelope_pan_shaper.sv
// Top level of the grain envelope and pan shaper.
//  channel | signals                         | direction
//  in      | in_valid in_ready in_data       | frame in
//  out     | out_valid out_ready out_data    | shaped frame out
//  cfg     | cfg_valid cfg_ready cfg_index   | register write
//          | cfg_data                        |
// Each frame passes through the serial 16-step divider and the log/exp
// iterations on one multiplier, run once for the attack and once for the
// decay factor; a new frame is accepted only once the last one is done.
// A finished result waits in the output register while the next frame is
// accepted. Reset clears control and the frame counter, presets config regs.
`timescale 1ns / 1ps
module grain_envelope_pan_shaper #(
	parameter int FRAME_COUNT_BITS = 16,
	parameter int LOG_TABLE_BITS   = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  gep_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output gep_pkg::out_item_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gep_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gep_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gep_pkg::*;

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	gep_ctrl #(
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	gep_datapath #(
		.FRAME_COUNT_BITS(FRAME_COUNT_BITS),
		.LOG_TABLE_BITS  (LOG_TABLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.out_data (out_data)
	);

endmodule

>>> rtl/gep_checker.sv
// Port-level checker for the shaper, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gep_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input gep_pkg::out_item_t out_data
);

	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`AST_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)
	`AST_IMP(a_out_from_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind grain_envelope_pan_shaper gep_checker u_chk (.*);
